// ===== src/ile_pkg.sv =====
// Shared types, request and response codes for the indexed list engine.
package ile_pkg;

    localparam int ILE_DEPTH      = 16;
    localparam int ILE_DATA_WIDTH = 32;

    // Request modes.
    localparam logic [2:0] ILE_MODE_ADD_FIRST    = 3'd0;
    localparam logic [2:0] ILE_MODE_ADD_LAST     = 3'd1;
    localparam logic [2:0] ILE_MODE_REMOVE_AT    = 3'd2;
    localparam logic [2:0] ILE_MODE_REMOVE_FIRST = 3'd3;
    localparam logic [2:0] ILE_MODE_GET_AT       = 3'd4;

    // Response status codes.
    localparam logic [1:0] ILE_ST_OK    = 2'd0;
    localparam logic [1:0] ILE_ST_RANGE = 2'd1;
    localparam logic [1:0] ILE_ST_EMPTY = 2'd2;
    localparam logic [1:0] ILE_ST_FULL  = 2'd3;

    // Operation broadcast to every cell of the row.
    typedef enum logic [1:0] {
        ILE_OP_HOLD,
        ILE_OP_PREPEND,
        ILE_OP_APPEND,
        ILE_OP_REMOVE
    } ile_op_t;

    typedef struct packed {
        logic [2:0]  mode;
        logic [31:0] value;
        logic [3:0]  position;
    } ile_req_t;

    typedef struct packed {
        logic [31:0] data;
        logic [4:0]  count;
        logic [1:0]  status;
    } ile_rsp_t;

endpackage

// ===== src/indexed_list_engine_core.sv =====
// Top level of the indexed list engine: request decode, cell row and response register.
// The block keeps an ordered list of up to DEPTH words in a row of cells, packed at
// positions 0 to count-1. A request may prepend or append a word, remove the word at a
// position, remove the first word, or read the word at a position; removal closes the gap
// and keeps the order. Every request gives exactly one response with the removed or read
// word (zero for inserts and errors), the count after the request and a status: out of
// range for a position at or beyond the count, empty for removing the first word of an
// empty list, full for an insert into a full list. Unused modes change nothing and report
// ok. All cells shift together on the edge that accepts a request, and the response is
// ready in the register on the next cycle. A new request is accepted in every cycle in
// which the response register is empty or being drained, so the sustained rate is one
// request per cycle. Only the first sixteen positions can be addressed, since the
// position field is four bits wide.
module indexed_list_engine_core #(
    parameter int DEPTH      = ile_pkg::ILE_DEPTH,
    parameter int DATA_WIDTH = ile_pkg::ILE_DATA_WIDTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  ile_pkg::ile_req_t req,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output ile_pkg::ile_rsp_t rsp
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    // Width wide enough to compare a four-bit position with the count.
    localparam int CMP_W = (CNT_W > 4) ? CNT_W : 4;
    // Number of cells that a four-bit position can reach.
    localparam int TAP_N = (DEPTH < 16) ? DEPTH : 16;

    logic [DATA_WIDTH-1:0] cell_q [DEPTH];
    logic [DATA_WIDTH-1:0] ins_word;
    logic [DATA_WIDTH-1:0] rd_word;
    logic [3:0]            tap_idx;

    logic [CNT_W-1:0]      cnt_reg;
    logic [CNT_W-1:0]      cnt_next;
    logic                  rsp_valid_reg;
    ile_pkg::ile_rsp_t     rsp_reg;
    ile_pkg::ile_rsp_t     rsp_next;

    ile_pkg::ile_op_t      op;
    logic [CNT_W-1:0]      sel;
    logic                  req_fire;
    logic                  is_full;
    logic                  is_empty;
    logic                  pos_ok;
    logic [DATA_WIDTH-1:0] resp_word;
    logic [1:0]            resp_status;

    // A request is taken whenever the response register is free or being emptied.
    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign req_fire  = req_valid && req_ready;

    assign ins_word = DATA_WIDTH'(req.value);
    assign is_full  = (cnt_reg == CNT_W'(DEPTH));
    assign is_empty = (cnt_reg == '0);
    assign pos_ok   = (CMP_W'(req.position) < CMP_W'(cnt_reg));

    // The read tap looks at the first cell for remove-first and at the requested
    // position otherwise.
    assign tap_idx = (req.mode == ile_pkg::ILE_MODE_REMOVE_FIRST) ? 4'd0 : req.position;

    // Read tap over the addressable cells.
    always_comb
    begin
        rd_word = '0;
        for (int i = 0; i < TAP_N; i++)
        begin
            if (tap_idx == 4'(i))
            begin
                rd_word = cell_q[i];
            end
        end
    end

    // Decode the request into one operation for the whole row.
    always_comb
    begin
        op          = ile_pkg::ILE_OP_HOLD;
        sel         = '0;
        cnt_next    = cnt_reg;
        resp_word   = '0;
        resp_status = ile_pkg::ILE_ST_OK;
        unique case (req.mode)
            ile_pkg::ILE_MODE_ADD_FIRST:
            begin
                if (is_full)
                begin
                    resp_status = ile_pkg::ILE_ST_FULL;
                end
                else
                begin
                    op       = ile_pkg::ILE_OP_PREPEND;
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ile_pkg::ILE_MODE_ADD_LAST:
            begin
                if (is_full)
                begin
                    resp_status = ile_pkg::ILE_ST_FULL;
                end
                else
                begin
                    op       = ile_pkg::ILE_OP_APPEND;
                    sel      = cnt_reg;
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ile_pkg::ILE_MODE_REMOVE_AT:
            begin
                if (!pos_ok)
                begin
                    resp_status = ile_pkg::ILE_ST_RANGE;
                end
                else
                begin
                    op        = ile_pkg::ILE_OP_REMOVE;
                    sel       = CNT_W'(req.position);
                    resp_word = rd_word;
                    cnt_next  = cnt_reg - CNT_W'(1);
                end
            end
            ile_pkg::ILE_MODE_REMOVE_FIRST:
            begin
                if (is_empty)
                begin
                    resp_status = ile_pkg::ILE_ST_EMPTY;
                end
                else
                begin
                    op        = ile_pkg::ILE_OP_REMOVE;
                    resp_word = rd_word;
                    cnt_next  = cnt_reg - CNT_W'(1);
                end
            end
            ile_pkg::ILE_MODE_GET_AT:
            begin
                if (!pos_ok)
                begin
                    resp_status = ile_pkg::ILE_ST_RANGE;
                end
                else
                begin
                    resp_word = rd_word;
                end
            end
            default:
            begin
                // Unused modes leave the list alone and report ok.
                op = ile_pkg::ILE_OP_HOLD;
            end
        endcase
        // The row only moves on the edge that accepts the request.
        if (!req_fire)
        begin
            op = ile_pkg::ILE_OP_HOLD;
        end
    end

    always_comb
    begin
        rsp_next.data   = 32'(resp_word);
        rsp_next.count  = 5'(cnt_next);
        rsp_next.status = resp_status;
    end

    // The row of cells. The first cell is fed the new word on a prepend, and the last
    // cell keeps its own word on a remove.
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        logic [DATA_WIDTH-1:0] left_word;
        logic [DATA_WIDTH-1:0] right_word;

        if (g == 0)
        begin : g_first
            assign left_word = ins_word;
        end
        else
        begin : g_inner_left
            assign left_word = cell_q[g-1];
        end

        if (g == DEPTH - 1)
        begin : g_last
            assign right_word = cell_q[g];
        end
        else
        begin : g_inner_right
            assign right_word = cell_q[g+1];
        end

        ile_cell #(
            .INDEX      (g),
            .DATA_WIDTH (DATA_WIDTH),
            .CNT_W      (CNT_W)
        ) u_cell (
            .clk   (clk),
            .op    (op),
            .sel   (sel),
            .ins   (ins_word),
            .left  (left_word),
            .right (right_word),
            .q     (cell_q[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (req_fire)
            begin
                cnt_reg       <= cnt_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // The response payload needs no reset; it is qualified by the valid flag.
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ===== src/ile_cell.sv =====
// One storage cell of the list row, holding the entry at a fixed position.
module ile_cell #(
    parameter int INDEX      = 0,
    parameter int DATA_WIDTH = ile_pkg::ILE_DATA_WIDTH,
    parameter int CNT_W      = $clog2(ile_pkg::ILE_DEPTH + 1)
) (
    input  logic                  clk,
    input  ile_pkg::ile_op_t      op,
    input  logic [CNT_W-1:0]      sel,
    input  logic [DATA_WIDTH-1:0] ins,
    input  logic [DATA_WIDTH-1:0] left,
    input  logic [DATA_WIDTH-1:0] right,
    output logic [DATA_WIDTH-1:0] q
);

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;
    logic                  sel_eq;
    logic                  sel_le;

    assign sel_eq = (sel == CNT_W'(INDEX));
    assign sel_le = (sel <= CNT_W'(INDEX));

    always_comb
    begin
        data_next = data_reg;
        unique case (op)
            ile_pkg::ILE_OP_HOLD:
            begin
                data_next = data_reg;
            end
            ile_pkg::ILE_OP_PREPEND:
            begin
                data_next = left;
            end
            ile_pkg::ILE_OP_APPEND:
            begin
                if (sel_eq)
                begin
                    data_next = ins;
                end
            end
            ile_pkg::ILE_OP_REMOVE:
            begin
                // Cells at and above the removed position take their upper neighbour.
                if (sel_le)
                begin
                    data_next = right;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign q = data_reg;

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the indexed list engine core.
`timescale 1ns / 100ps

module tb_top;

    // The package only names the five real modes; these bound the spare ones.
    localparam logic [2:0] MODE_SPARE_LO = 3'd5;
    localparam logic [2:0] MODE_SPARE_HI = 3'd7;

    // Cycles without a single accepted request or response before the run is
    // declared hung. The slowest correct item needs roughly a long sender gap
    // plus a long receiver stall, so this is generous.
    localparam int QUIET_LIMIT    = 2000;
    // Cycles to wait after the last response.
    localparam int SETTLE_CYCLES  = 10;
    localparam int ROUND_REQUESTS = 250;

    logic               clk;
    logic               rst_n;
    logic               req_valid;
    logic               req_ready;
    ile_pkg::ile_req_t  req;
    logic               rsp_valid;
    logic               rsp_ready;
    ile_pkg::ile_rsp_t  rsp;

    // Predicted list contents, kept packed at positions 0 .. list_len-1.
    logic [ile_pkg::ILE_DATA_WIDTH-1:0] list_words [ile_pkg::ILE_DEPTH];
    int unsigned                        list_len;

    // Responses predicted for accepted requests, oldest first.
    ile_pkg::ile_rsp_t awaited_responses [$];

    int  mismatch_count;
    int  quiet_cycles;
    int  stall_left;
    bit  sender_steady;
    bit  receiver_steady;

    indexed_list_engine_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Idle lengths: half of them none, most of the rest short, a few long.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
        begin
            return 0;
        end
        else if (roll < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 20);
    endfunction

    // Applies one request to the predicted list and returns the response the
    // block must give. Inserts report full when all cells are taken; removals
    // and reads at a position at or beyond the count close nothing and report
    // out of range; removing the first entry of an empty list reports empty.
    // Spare modes leave everything alone and report ok.
    function automatic ile_pkg::ile_rsp_t apply_list_request(input ile_pkg::ile_req_t r);
        ile_pkg::ile_rsp_t result;
        int unsigned       slot;
        result.data   = '0;
        result.status = ile_pkg::ILE_ST_OK;
        case (r.mode)
            ile_pkg::ILE_MODE_ADD_FIRST:
            begin
                if (list_len >= ile_pkg::ILE_DEPTH)
                begin
                    result.status = ile_pkg::ILE_ST_FULL;
                end
                else
                begin
                    for (slot = list_len; slot > 0; slot--)
                    begin
                        list_words[slot] = list_words[slot-1];
                    end
                    list_words[0] = r.value;
                    list_len++;
                end
            end
            ile_pkg::ILE_MODE_ADD_LAST:
            begin
                if (list_len >= ile_pkg::ILE_DEPTH)
                begin
                    result.status = ile_pkg::ILE_ST_FULL;
                end
                else
                begin
                    list_words[list_len] = r.value;
                    list_len++;
                end
            end
            ile_pkg::ILE_MODE_REMOVE_AT, ile_pkg::ILE_MODE_REMOVE_FIRST:
            begin
                slot = (r.mode == ile_pkg::ILE_MODE_REMOVE_AT) ? r.position : 0;
                if (list_len == 0 && r.mode == ile_pkg::ILE_MODE_REMOVE_FIRST)
                begin
                    result.status = ile_pkg::ILE_ST_EMPTY;
                end
                else if (slot >= list_len)
                begin
                    result.status = ile_pkg::ILE_ST_RANGE;
                end
                else
                begin
                    result.data = list_words[slot];
                    while (slot + 1 < list_len)
                    begin
                        list_words[slot] = list_words[slot+1];
                        slot++;
                    end
                    list_len--;
                end
            end
            ile_pkg::ILE_MODE_GET_AT:
            begin
                if (r.position >= list_len)
                begin
                    result.status = ile_pkg::ILE_ST_RANGE;
                end
                else
                begin
                    result.data = list_words[r.position];
                end
            end
            default:
            begin
            end
        endcase
        result.count = list_len[4:0];
        return result;
    endfunction

    function automatic ile_pkg::ile_req_t make_request(input logic [2:0] mode,
                                                       input logic [31:0] value,
                                                       input logic [3:0] position);
        ile_pkg::ile_req_t r;
        r.mode     = mode;
        r.value    = value;
        r.position = position;
        return r;
    endfunction

    // Random request shaped by the current predicted length: positions mostly
    // land inside the list, and the mix leans towards filling or draining so
    // that both the full and the empty corners are visited often.
    function automatic ile_pkg::ile_req_t make_random_request(input bit fill_bias);
        ile_pkg::ile_req_t r;
        int                roll;
        r.value    = $urandom;
        r.position = 4'($urandom_range(0, 15));
        roll = $urandom_range(0, 99);
        if (roll < 5)
        begin
            r.value = (roll < 2) ? '0 : '1;
        end
        roll = $urandom_range(0, 99);
        if (roll < 3)
        begin
            r.mode = 3'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
        end
        else if (roll < (fill_bias ? 60 : 30))
        begin
            r.mode = $urandom_range(0, 1) ? ile_pkg::ILE_MODE_ADD_FIRST
                                          : ile_pkg::ILE_MODE_ADD_LAST;
        end
        else if (roll < (fill_bias ? 70 : 55))
        begin
            r.mode = ile_pkg::ILE_MODE_REMOVE_AT;
        end
        else if (roll < (fill_bias ? 80 : 75))
        begin
            r.mode = ile_pkg::ILE_MODE_REMOVE_FIRST;
        end
        else
        begin
            r.mode = ile_pkg::ILE_MODE_GET_AT;
        end
        if ((r.mode == ile_pkg::ILE_MODE_REMOVE_AT || r.mode == ile_pkg::ILE_MODE_GET_AT) &&
            list_len > 0 && $urandom_range(0, 9) != 0)
        begin
            r.position = 4'($urandom_range(0, list_len - 1));
        end
        return r;
    endfunction

    // Presents one request from a falling edge and returns at the falling edge
    // after it has been accepted. Valid is only dropped when a gap is wanted,
    // so back-to-back requests keep it high throughout.
    task automatic send_request(input ile_pkg::ile_req_t item);
        int gap;
        gap = sender_steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        do
        begin
            @(posedge clk);
        end
        while (!req_ready);
        @(negedge clk);
    endtask

    // Holds the sender back until every predicted response has been taken.
    task automatic wait_for_responses();
        req_valid <= 1'b0;
        while (awaited_responses.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    // Requests on an empty list: both removals and a read must fail, and
    // the spare modes must do nothing at all.
    task automatic test_empty_list();
        logic [2:0] spare;
        send_request(make_request(ile_pkg::ILE_MODE_REMOVE_FIRST, 32'h1234_5678, 4'd0));
        send_request(make_request(ile_pkg::ILE_MODE_GET_AT, 32'h0, 4'd0));
        send_request(make_request(ile_pkg::ILE_MODE_REMOVE_AT, 32'hFFFF_FFFF, 4'd15));
        for (spare = MODE_SPARE_LO; spare <= MODE_SPARE_HI && spare != 3'd0; spare++)
        begin
            send_request(make_request(spare, 32'hFFFF_FFFF, 4'd15));
        end
    endtask

    // Fills the list from both ends with extreme and random words, then tries
    // both inserts on the full list and works the last position.
    task automatic test_full_list();
        int k;
        send_request(make_request(ile_pkg::ILE_MODE_ADD_LAST, 32'h0, 4'd0));
        send_request(make_request(ile_pkg::ILE_MODE_ADD_FIRST, 32'hFFFF_FFFF, 4'd15));
        for (k = 2; k < ile_pkg::ILE_DEPTH; k++)
        begin
            send_request(make_request(k[0] ? ile_pkg::ILE_MODE_ADD_FIRST
                                           : ile_pkg::ILE_MODE_ADD_LAST,
                                      $urandom, 4'($urandom_range(0, 15))));
        end
        send_request(make_request(ile_pkg::ILE_MODE_ADD_FIRST, 32'hA5A5_A5A5, 4'd0));
        send_request(make_request(ile_pkg::ILE_MODE_ADD_LAST, 32'h5A5A_5A5A, 4'd0));
        send_request(make_request(ile_pkg::ILE_MODE_GET_AT, 32'h0, 4'd15));
        send_request(make_request(ile_pkg::ILE_MODE_REMOVE_AT, 32'h0, 4'd15));
        send_request(make_request(ile_pkg::ILE_MODE_GET_AT, 32'h0, 4'd15));
        send_request(make_request(ile_pkg::ILE_MODE_REMOVE_FIRST, 32'h0, 4'd0));
    endtask

    // Rounds that alternate between filling and draining, each with a mix of
    // idling on the two sides that is set by the round number.
    task automatic test_random_traffic(input int rounds);
        int round;
        int k;
        for (round = 0; round < rounds; round++)
        begin
            sender_steady   = (round % 3 == 1);
            receiver_steady = (round % 4 == 2);
            for (k = 0; k < ROUND_REQUESTS; k++)
            begin
                send_request(make_random_request(round[0] == 1'b0));
            end
        end
        sender_steady   = 1'b0;
        receiver_steady = 1'b0;
    endtask

    // Full rate on both sides, switching bias every fifty requests.
    task automatic test_back_to_back();
        int k;
        sender_steady   = 1'b1;
        receiver_steady = 1'b1;
        for (k = 0; k < 300; k++)
        begin
            send_request(make_random_request((k / 50) % 2 == 0));
        end
        sender_steady   = 1'b0;
        receiver_steady = 1'b0;
    endtask

    // The sender stops until the block has handed back every response, then
    // carries on; a few such pauses land in different list states.
    task automatic test_paused_sender();
        int pause;
        int k;
        for (pause = 0; pause < 4; pause++)
        begin
            for (k = 0; k < 50; k++)
            begin
                send_request(make_random_request(pause < 2));
            end
            wait_for_responses();
        end
    endtask

    // Receiver: ready most of the time, with stalls of random length, and
    // stretches without any stall when receiver_steady is set.
    initial
    begin : response_sink
        rsp_ready  = 1'b0;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                rsp_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                rsp_ready <= 1'b1;
                if (!receiver_steady && $urandom_range(0, 3) == 0)
                begin
                    stall_left = pick_gap();
                end
            end
        end
    end

    // Every accepted request is run through the predictor straight away.
    always @(posedge clk)
    begin : request_monitor
        if (rst_n && req_valid && req_ready)
        begin
            awaited_responses.push_back(apply_list_request(req));
        end
    end

    // Every accepted response is compared with the oldest prediction.
    always @(posedge clk)
    begin : response_checker
        ile_pkg::ile_rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (awaited_responses.size() == 0)
            begin
                $error("response with none outstanding: data %h count %0d status %0d",
                       rsp.data, rsp.count, rsp.status);
                mismatch_count++;
            end
            else
            begin
                want = awaited_responses.pop_front();
                if (rsp.data !== want.data)
                begin
                    $error("data mismatch: expected %h, actual %h", want.data, rsp.data);
                    mismatch_count++;
                end
                if (rsp.count !== want.count)
                begin
                    $error("count mismatch: expected %0d, actual %0d", want.count, rsp.count);
                    mismatch_count++;
                end
                if (rsp.status !== want.status)
                begin
                    $error("status mismatch: expected %0d, actual %0d",
                           want.status, rsp.status);
                    mismatch_count++;
                end
            end
        end
    end

    // Counts cycles in which neither side moves anything.
    always @(posedge clk)
    begin : quiet_counter
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin : watchdog
        do
        begin
            @(posedge clk);
        end
        while (quiet_cycles < QUIET_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    initial
    begin : main_sequence
        int settle;
        rst_n           = 1'b0;
        req_valid       = 1'b0;
        req             = '0;
        list_len        = 0;
        mismatch_count  = 0;
        quiet_cycles    = 0;
        sender_steady   = 1'b0;
        receiver_steady = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_empty_list();
        test_full_list();
        test_random_traffic(5);
        test_back_to_back();
        test_paused_sender();

        // Let the last responses arrive, then give any stray one time to show.
        wait_for_responses();
        for (settle = 0; settle < SETTLE_CYCLES; settle++)
        begin
            @(posedge clk);
        end
        if (mismatch_count == 0 && awaited_responses.size() == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
